// File: rtl/ycbcr420_to_rgb_converter_core_macros.svh
// ----------------------------------------------------------------------------
// YCbCr 4:2:0 to RGB converter - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef YCBCR420_TO_RGB_CONVERTER_CORE_MACROS_SVH
`define YCBCR420_TO_RGB_CONVERTER_CORE_MACROS_SVH

// same-cycle implication
`define YCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication
`define YCC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: rtl/ycc2rgb_pkg.sv
// ----------------------------------------------------------------------------
// YCbCr 4:2:0 to RGB converter - package
// Request types, operation codes, register indexes and shared constants.
// ----------------------------------------------------------------------------
package ycc2rgb_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        OP_LOAD_CB = 2'd0,
        OP_LOAD_CR = 2'd1,
        OP_PIXEL   = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [8:0] row;
        logic [8:0] col;
        logic [7:0] sample;
    } cmd_req_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } rgb_req_t;

endpackage

// File: rtl/ycc2rgb_ram.sv
// ----------------------------------------------------------------------------
// YCbCr 4:2:0 to RGB converter - generic RAM
// One write port, one read port with registered read data held while the
// read enable is low.
// ----------------------------------------------------------------------------
module ycc2rgb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/ycbcr420_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// YCbCr 4:2:0 to RGB converter - top level
// BT.601 studio-range YCbCr to RGB with nearest-neighbor chroma upsampling.
// ----------------------------------------------------------------------------
// Takes one request per clock while cmd_stall is low, loads and pixels
// alike. A pixel's RGB result passes in order through the input register,
// the chroma RAM read, the coefficient multiply and the sum/floor/clamp
// output register. Loads write the Cb or Cr byte into separate byte-wide
// chroma RAMs of (MAX_HEIGHT/2)*(MAX_WIDTH/2) entries and give no result; a
// pixel sees every load accepted before it. Chroma is undefined until loaded
// and there is no clearing pass after reset. Each stage holds its request
// under output stall and frees up as soon as the stage after it moves, so
// bubbles are filled while a result waits. The user must write frame_width
// and frame_height only while the pipeline is empty; the block itself does
// not enforce it.
// ----------------------------------------------------------------------------
`include "ycbcr420_to_rgb_converter_core_macros.svh"

module ycbcr420_to_rgb_converter_core
    import ycc2rgb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  cmd_req_t             cmd_req,
    output logic                 rgb_valid,
    input  logic                 rgb_stall,
    output rgb_req_t             rgb_req,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int CH_COLS = MAX_WIDTH / 2;
    localparam int CH_ROWS = MAX_HEIGHT / 2;
    localparam int DEPTH   = CH_ROWS * CH_COLS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W  = 20;
    localparam int FRAC_W  = 10;

    localparam logic signed [PROD_W-1:0] K_Y  = 20'sd1192;
    localparam logic signed [PROD_W-1:0] K_RV = 20'sd1634;
    localparam logic signed [PROD_W-1:0] K_GU = 20'sd401;
    localparam logic signed [PROD_W-1:0] K_GV = 20'sd833;
    localparam logic signed [PROD_W-1:0] K_BU = 20'sd2065;

    function automatic logic [7:0] to_channel(input logic signed [PROD_W-1:0] s);
        logic signed [PROD_W-1:0] q;
        logic [7:0]               c;
        q = s >>> FRAC_W;
        if (s < 0)
            c = 8'd0;
        else if (q > PROD_W'(255))
            c = 8'd255;
        else
            c = q[7:0];
        return c;
    endfunction

    // configuration
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CFG_W'(512);
            frame_height_reg <= CFG_W'(512);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage handshake
    logic v1_reg, v2_reg, v3_reg, rgb_valid_reg;
    logic ready1, ready2, ready3, ready_out;

    assign ready_out = !rgb_valid_reg || !rgb_stall;
    assign ready3    = !v3_reg || ready_out;
    assign ready2    = !v2_reg || ready3;
    assign ready1    = !v1_reg || ready2;
    assign cmd_stall = !ready1;

    // stage 1: address and frame-end decode
    logic [1:0]        op1_reg, op1_next;
    logic [ADDR_W-1:0] addr1_reg, addr1_next;
    logic              ok1_reg, ok1_next;
    logic [7:0]        smp1_reg;
    logic              fe1_reg, fe1_next;
    logic [8:0]        sel_row, sel_col;

    always_comb
    begin
        op1_next = cmd_req.operation;
        if (cmd_req.operation == OP_PIXEL)
        begin
            sel_row = {1'b0, cmd_req.row[8:1]};
            sel_col = {1'b0, cmd_req.col[8:1]};
        end
        else
        begin
            sel_row = cmd_req.row;
            sel_col = cmd_req.col;
        end
        addr1_next = ADDR_W'(ADDR_W'(sel_row) * ADDR_W'(CH_COLS) + ADDR_W'(sel_col));
        ok1_next   = (32'(sel_row) < CH_ROWS) && (32'(sel_col) < CH_COLS);
        fe1_next   = ({1'b0, cmd_req.row} == (frame_height_reg - CFG_W'(1))) &&
                     ({1'b0, cmd_req.col} == (frame_width_reg - CFG_W'(1)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (ready1)
            v1_reg <= cmd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            op1_reg   <= op1_next;
            addr1_reg <= addr1_next;
            ok1_reg   <= ok1_next;
            smp1_reg  <= cmd_req.sample;
            fe1_reg   <= fe1_next;
        end
    end

    // chroma store
    logic       cb_we, cr_we;
    logic [7:0] cb_rdata, cr_rdata;

    assign cb_we = v1_reg && ok1_reg && ready2 && (op1_reg == OP_LOAD_CB);
    assign cr_we = v1_reg && ok1_reg && ready2 && (op1_reg == OP_LOAD_CR);

    ycc2rgb_ram #(.WIDTH(8), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_cb_ram (
        .clk   (clk),
        .we    (cb_we),
        .waddr (addr1_reg),
        .wdata (smp1_reg),
        .re    (ready2),
        .raddr (addr1_reg),
        .rdata (cb_rdata)
    );

    ycc2rgb_ram #(.WIDTH(8), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_cr_ram (
        .clk   (clk),
        .we    (cr_we),
        .waddr (addr1_reg),
        .wdata (smp1_reg),
        .re    (ready2),
        .raddr (addr1_reg),
        .rdata (cr_rdata)
    );

    // stage 2: chroma read, pixels only
    logic       v2_next;
    logic       ok2_reg;
    logic [7:0] smp2_reg;
    logic       fe2_reg;

    assign v2_next = v1_reg && (op1_reg == OP_PIXEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (ready2)
            v2_reg <= v2_next;
    end

    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            ok2_reg  <= ok1_reg;
            smp2_reg <= smp1_reg;
            fe2_reg  <= fe1_reg;
        end
    end

    // stage 3: clamp and multiply
    logic [7:0]               cb_byte, cr_byte, y_off;
    logic signed [7:0]        cb_off, cr_off;
    logic [8:0]               cb_diff, cr_diff;
    logic signed [PROD_W-1:0] y_ext, cb_ext, cr_ext;
    logic signed [PROD_W-1:0] py3_reg, prv3_reg, pgu3_reg, pgv3_reg, pbu3_reg;
    logic signed [PROD_W-1:0] py3_next, prv3_next, pgu3_next, pgv3_next, pbu3_next;
    logic                     fe3_reg;

    always_comb
    begin
        cb_byte = ok2_reg ? cb_rdata : 8'd0;
        cr_byte = ok2_reg ? cr_rdata : 8'd0;

        if (smp2_reg < 8'd16)
            y_off = 8'd0;
        else if (smp2_reg > 8'd235)
            y_off = 8'd219;
        else
            y_off = smp2_reg - 8'd16;

        if (cb_byte < 8'd16)
            cb_diff = 9'h190;
        else if (cb_byte > 8'd240)
            cb_diff = 9'd112;
        else
            cb_diff = {1'b0, cb_byte} - 9'd128;

        if (cr_byte < 8'd16)
            cr_diff = 9'h190;
        else if (cr_byte > 8'd240)
            cr_diff = 9'd112;
        else
            cr_diff = {1'b0, cr_byte} - 9'd128;

        cb_off = signed'(cb_diff[7:0]);
        cr_off = signed'(cr_diff[7:0]);
        y_ext  = signed'(PROD_W'(y_off));
        cb_ext = PROD_W'(cb_off);
        cr_ext = PROD_W'(cr_off);

        py3_next  = y_ext * K_Y;
        prv3_next = cr_ext * K_RV;
        pgu3_next = cb_ext * K_GU;
        pgv3_next = cr_ext * K_GV;
        pbu3_next = cb_ext * K_BU;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (ready3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready3)
        begin
            py3_reg  <= py3_next;
            prv3_reg <= prv3_next;
            pgu3_reg <= pgu3_next;
            pgv3_reg <= pgv3_next;
            pbu3_reg <= pbu3_next;
            fe3_reg  <= fe2_reg;
        end
    end

    // stage 4: sum, floor, clamp
    logic signed [PROD_W-1:0] sum_r, sum_g, sum_b;
    rgb_req_t                 rgb_req_reg, rgb_req_next;

    always_comb
    begin
        sum_r = py3_reg + prv3_reg;
        sum_g = py3_reg - pgu3_reg - pgv3_reg;
        sum_b = py3_reg + pbu3_reg;
        rgb_req_next.red       = to_channel(sum_r);
        rgb_req_next.green     = to_channel(sum_g);
        rgb_req_next.blue      = to_channel(sum_b);
        rgb_req_next.frame_end = fe3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rgb_valid_reg <= 1'b0;
        else if (ready_out)
            rgb_valid_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready_out)
        begin
            rgb_req_reg <= rgb_req_next;
        end
    end

    assign rgb_valid = rgb_valid_reg;
    assign rgb_req   = rgb_req_reg;

    // checks
    `YCC_ASSERT_IMP(a_idle_out_no_stall, clk, rst_n, !rgb_valid_reg, !cmd_stall)
    `YCC_ASSERT_NXT(a_load_no_result, clk, rst_n, v1_reg && (op1_reg != OP_PIXEL) && ready2, !v2_reg)
    `YCC_ASSERT_NXT(a_pixel_reaches_out, clk, rst_n, v3_reg && ready_out, rgb_valid)

endmodule
